/* src/plp_pkg.sv */
// shared types, constants and register codes of the preamble/length frame parser
package plp_pkg;

  localparam int unsigned PAYLOAD_DEPTH_DEF = 256;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned LEN_W    = 24;
  localparam int unsigned LCNT_W   = 2;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [LCNT_W-1:0]    lcnt_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam word_t PREAMBLE_RESET = 32'd4277062093;
  localparam byte_t TYPE_A_RESET   = 8'd1;
  localparam byte_t TYPE_B_RESET   = 8'd2;
  localparam lcnt_t LEN_BYTES      = 2'd3;

  // configuration register indexes
  localparam cfg_idx_t CFG_IDX_PREAMBLE = 2'd0;
  localparam cfg_idx_t CFG_IDX_TYPE_A   = 2'd1;
  localparam cfg_idx_t CFG_IDX_TYPE_B   = 2'd2;

  typedef enum logic [3:0] {
    PH_SEEK    = 4'b0001,
    PH_TYPE    = 4'b0010,
    PH_LEN     = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_t;

  typedef struct packed {
    word_t preamble_word;
    byte_t accepted_type_a;
    byte_t accepted_type_b;
  } plp_cfg_t;

  typedef struct packed {
    logic  store_valid;
    byte_t store_index;
    byte_t store_byte;
    logic  header_found;
    logic  frame_done;
    byte_t frame_type;
  } plp_result_t;

endpackage

/* src/preamble_length_packet_parser.sv */
// top level of the preamble/type/length frame parser
// Takes one received byte per transaction and returns exactly one result per byte, in order.
// A byte is registered on input and parsed once it is held and the result register is free or
// draining (preamble window compare, type capture, length shift or payload countdown). Its result
// is registered on output, and while out_ready is held high the block sustains one byte per
// cycle; the throughput is set by the parse step that updates the parser state.
// While a finished result waits on out_ready the input register takes at most one more byte,
// then in_ready drops until the result is taken.
// Configuration writes take effect in the next cycle and are meant for an idle block.
module preamble_length_packet_parser
  import plp_pkg::*;
#(
  parameter int unsigned PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,

  input  logic     in_valid,
  output logic     in_ready,
  input  byte_t    in_rx_byte,

  output logic     out_valid,
  input  logic     out_ready,
  output logic     out_store_valid,
  output byte_t    out_store_index,
  output byte_t    out_store_byte,
  output logic     out_header_found,
  output logic     out_frame_done,
  output byte_t    out_frame_type,

  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  cfg_idx_t cfg_index,
  input  word_t    cfg_data
);

  plp_cfg_t    cfg;
  plp_result_t res;
  plp_result_t out_res_r;
  logic        in_vld_r, in_vld_nxt;
  byte_t       in_byte_r;
  logic        out_vld_r, out_vld_nxt;
  logic        in_fire;
  logic        step;

  plp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  plp_core #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  // parse when a byte is held and the result register is free or draining
  assign step     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || step;
  assign in_fire  = in_valid && in_ready;

  assign in_vld_nxt  = in_fire || (in_vld_r && !step);
  assign out_vld_nxt = step || (out_vld_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_rx_byte;
    end
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_store_valid  = out_res_r.store_valid;
  assign out_store_index  = out_res_r.store_index;
  assign out_store_byte   = out_res_r.store_byte;
  assign out_header_found = out_res_r.header_found;
  assign out_frame_done   = out_res_r.frame_done;
  assign out_frame_type   = out_res_r.frame_type;

endmodule

/* src/plp_cfg_regs.sv */
// configuration register file: preamble pattern and the two stored frame types
module plp_cfg_regs
  import plp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  cfg_idx_t cfg_index,
  input  word_t    cfg_data,
  output plp_cfg_t cfg_o
);

  plp_cfg_t cfg_r;
  plp_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IDX_PREAMBLE: cfg_nxt.preamble_word   = cfg_data;
        CFG_IDX_TYPE_A:   cfg_nxt.accepted_type_a = cfg_data[BYTE_W-1:0];
        CFG_IDX_TYPE_B:   cfg_nxt.accepted_type_b = cfg_data[BYTE_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.preamble_word   <= PREAMBLE_RESET;
      cfg_r.accepted_type_a <= TYPE_A_RESET;
      cfg_r.accepted_type_b <= TYPE_B_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* src/plp_core.sv */
// parser state and the one-byte parse step
module plp_core
  import plp_pkg::*;
#(
  parameter int unsigned PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  byte_t       rx_byte,
  input  plp_cfg_t    cfg,
  output plp_result_t res
);

  localparam int unsigned POS_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(PAYLOAD_DEPTH - 1);

  phase_t           phase_r, phase_nxt;
  word_t            window_r, window_nxt;
  byte_t            type_r, type_nxt;
  len_t             rem_r, rem_nxt;
  lcnt_t            lcnt_r, lcnt_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             end_frame;

  always_comb begin
    phase_nxt  = phase_r;
    window_nxt = window_r;
    type_nxt   = type_r;
    rem_nxt    = rem_r;
    lcnt_nxt   = lcnt_r;
    pos_nxt    = pos_r;
    end_frame  = 1'b0;
    res        = '0;

    unique case (phase_r)
      PH_SEEK: begin
        window_nxt = {window_r[WORD_W-BYTE_W-1:0], rx_byte};
        if (window_nxt == cfg.preamble_word) begin
          phase_nxt        = PH_TYPE;
          res.header_found = 1'b1;
        end
      end
      PH_TYPE: begin
        type_nxt  = rx_byte;
        phase_nxt = PH_LEN;
        lcnt_nxt  = '0;
        rem_nxt   = '0;
      end
      PH_LEN: begin
        lcnt_nxt = lcnt_r + 1'b1;
        rem_nxt  = {rem_r[LEN_W-BYTE_W-1:0], rx_byte};
        if (lcnt_nxt == LEN_BYTES) begin
          phase_nxt = PH_PAYLOAD;
          end_frame = (rem_nxt == '0);
        end
      end
      PH_PAYLOAD: begin
        if (type_r == cfg.accepted_type_a || type_r == cfg.accepted_type_b) begin
          res.store_valid = 1'b1;
          res.store_index = BYTE_W'(pos_r);
          res.store_byte  = rx_byte;
          pos_nxt = (pos_r == POS_LAST) ? '0 : pos_r + 1'b1;
        end
        rem_nxt   = rem_r - 1'b1;
        end_frame = (rem_nxt == '0);
      end
      default: begin
        phase_nxt = PH_SEEK;
      end
    endcase

    // frame end keeps the type but drops everything else
    if (end_frame) begin
      phase_nxt  = PH_SEEK;
      window_nxt = '0;
      rem_nxt    = '0;
      lcnt_nxt   = '0;
      pos_nxt    = '0;
    end

    res.frame_done = end_frame;
    res.frame_type = type_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEEK;
      window_r <= '0;
      type_r   <= '0;
      rem_r    <= '0;
      lcnt_r   <= '0;
      pos_r    <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      window_r <= window_nxt;
      type_r   <= type_nxt;
      rem_r    <= rem_nxt;
      lcnt_r   <= lcnt_nxt;
      pos_r    <= pos_nxt;
    end
  end

endmodule
